// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the priority task scheduler
// Slot and level sizing, task status codes, operation codes, payload
// structs and the per-slot record kept in the task memory.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int LEVELS     = 5;
  localparam int CFG_REGS   = 5;
  localparam int QDEPTH     = 2;

  localparam int SW  = $clog2(TASK_SLOTS);      // slot index width
  localparam int PW  = $clog2(TASK_SLOTS + 1);  // link width, holds the empty marker
  localparam int LVW = $clog2(LEVELS);          // level array index width

  localparam logic [PW-1:0] NIL = PW'(TASK_SLOTS);
  localparam logic [2:0] NORMAL_LEVEL = (LEVELS > 2) ? 3'd2 : 3'(LEVELS - 1);

  // request mode codes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_READY  = 3'd1;
  localparam logic [2:0] MODE_YIELD  = 3'd2;
  localparam logic [2:0] MODE_SLEEP  = 3'd3;
  localparam logic [2:0] MODE_EXIT   = 3'd4;
  localparam logic [2:0] MODE_SETPRI = 3'd5;

  // task status codes
  localparam logic [2:0] ST_FREE  = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_SLEEP = 3'd3;
  localparam logic [2:0] ST_TERM  = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK, OP_READY, OP_YIELD, OP_SLEEP, OP_EXIT, OP_SETPRI, OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  task_req;
    logic [2:0]  priority_req;
    logic [63:0] now_us;
    logic [31:0] sleep_us;
  } in_t;

  typedef struct packed {
    logic [5:0]  running_task;
    logic        switched;
    logic [2:0]  running_priority;
    logic [23:0] slice_left;
    logic        accepted;
  } out_t;

  // classified request as it travels through the queue
  typedef struct packed {
    op_t         op;
    logic [5:0]  slot;
    logic        req_ok;
    logic [2:0]  level;
    logic        plain;   // behaves as a plain yield
    logic [63:0] now;
    logic [63:0] wake;    // saturated wake time for sleep
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  level;
    logic [23:0] slice;
    logic [23:0] quantum;
  } rec_t;

  function automatic logic [23:0] quantum_reset(input int lv);
    logic [23:0] q;
    case (lv)
      0:       q = 24'd1000;
      1:       q = 24'd4000;
      2:       q = 24'd6000;
      3:       q = 24'd8000;
      default: q = 24'd12000;
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler: multilevel priority round-robin task scheduler
// Five level ready queues, sorted sleep list, tick based slice charging.
//
//   channel  handshake          payload
//   in_      in_valid/in_ready  pts_pkg::in_t   (one request)
//   out_     out_valid/out_ready pts_pkg::out_t (one result per request)
//   cfg_     cfg_valid/cfg_ready cfg_index, cfg_data (level quanta)
//
// A tick wakes due sleepers, charges the running task and may dispatch.
// List work covers ready queue pushes, woken sleepers, unlinks that walk
// a list node by node, and sorted inserts into the sleep list.
// After reset a clearing pass over all 64 slots runs with in_ready low.
// A two-entry queue decouples intake from the sequencer; the result
// register lets the next request start while a result waits.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pts_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pts_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);
  import pts_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_full, q_valid, q_pop, clearing;

  assign cfg_ready = 1'b1;

  pts_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (f_push),
    .cmd      (f_cmd)
  );

  pts_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_cmd)
  );

  pts_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/pts_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_fifo: request queue between front end and scheduler engine
// Small register FIFO of classified requests.
// ----------------------------------------------------------------------------
module pts_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pts_pkg::cmd_t  wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pts_pkg::cmd_t  rdata
);
  import pts_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  // pointer and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_front: request intake and classification
// Accepts requests, decodes the mode, maps the level and precomputes the
// saturated wake time before the request enters the queue.
// ----------------------------------------------------------------------------
module pts_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  pts_pkg::in_t   in_data,
  input  logic           q_full,
  input  logic           clearing,
  output logic           push,
  output pts_pkg::cmd_t  cmd
);
  import pts_pkg::*;

  logic [64:0] wake_sum;

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;
  assign wake_sum = {1'b0, in_data.now_us} + {33'd0, in_data.sleep_us};

  always_comb begin
    unique case (in_data.mode)
      MODE_TICK:   cmd.op = OP_TICK;
      MODE_READY:  cmd.op = OP_READY;
      MODE_YIELD:  cmd.op = OP_YIELD;
      MODE_SLEEP:  cmd.op = OP_SLEEP;
      MODE_EXIT:   cmd.op = OP_EXIT;
      MODE_SETPRI: cmd.op = OP_SETPRI;
      default:     cmd.op = OP_NOP;
    endcase
    cmd.slot   = in_data.task_req;
    cmd.req_ok = (32'(in_data.task_req) < 32'(TASK_SLOTS));
    cmd.level  = (32'(in_data.priority_req) < 32'(LEVELS)) ? in_data.priority_req
                                                            : NORMAL_LEVEL;
    cmd.plain  = (in_data.mode == MODE_YIELD) || (in_data.sleep_us == '0);
    cmd.now    = in_data.now_us;
    // wake time saturates at all ones
    cmd.wake   = wake_sum[64] ? '1 : wake_sum[63:0];
  end

endmodule

// ===== rtl/pts_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_engine: scheduler sequencer
// Executes queued requests against the task, wake and link memories:
// ready queues per level, sorted sleep list, tick charging and dispatch.
// ----------------------------------------------------------------------------
module pts_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data,
  input  logic           q_valid,
  input  pts_pkg::cmd_t  q_data,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output pts_pkg::out_t  out_data
);
  import pts_pkg::*;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_T0, S_W0, S_W1, S_WDONE, S_T2, S_SEL, S_DISP,
    S_R1, S_R2, S_Y1, S_X1, S_S1, S_S2, S_P0, S_P1,
    S_RM0, S_RM1, S_RM2, S_SI0, S_SI1, S_SI2, S_SI3, S_SI4, S_SI5, S_SI6,
    S_FIN0, S_FIN1
  } state_t;

  state_t        st_r, st_nxt, ret_r, ret_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] running_r, running_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [PW-1:0] sh_r, sh_nxt;
  logic [PW-1:0] head_r [LEVELS];
  logic [PW-1:0] head_nxt [LEVELS];
  logic [PW-1:0] tail_r [LEVELS];
  logic [PW-1:0] tail_nxt [LEVELS];
  logic [23:0]   qreg_r [LEVELS];
  logic [23:0]   qreg_nxt [LEVELS];
  logic [PW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [2:0]    lv_r, lv_nxt;
  logic [63:0]   last_r, last_nxt, ws_r, ws_nxt;
  logic [23:0]   diff_r, diff_nxt;
  logic          force_r, force_nxt, spend_r, spend_nxt;
  logic          forced_r, forced_nxt, tosleep_r, tosleep_nxt;
  logic          rmsl_r, rmsl_nxt, found_r, found_nxt;
  logic          acc_r, acc_nxt, sw_r, sw_nxt;
  logic          ov_r, ov_nxt;
  out_t          out_r, out_nxt;

  // memory ports
  rec_t          rec_mem [TASK_SLOTS];
  logic [63:0]   wake_mem [TASK_SLOTS];
  logic [PW-1:0] link_mem [TASK_SLOTS];
  rec_t          rec_q, rec_wd;
  logic [63:0]   wake_q, wake_wd;
  logic [PW-1:0] link_q, link_wd;
  logic [SW-1:0] rec_ra, rec_wa, wake_ra, wake_wa, link_ra, link_wa;
  logic          rec_we, wake_we, link_we;

  // highest non-empty level
  logic          hr_found;
  logic [2:0]    hr_lv;
  logic          ht_ok;

  always_comb begin
    hr_found = 1'b0;
    hr_lv    = '0;
    ht_ok    = 1'b1;
    for (int l = 0; l < LEVELS; l++) begin
      if (head_r[l] != NIL) begin
        hr_found = 1'b1;
        hr_lv    = 3'(l);
      end
      if ((head_r[l] == NIL) != (tail_r[l] == NIL)) begin
        ht_ok = 1'b0;
      end
    end
  end

  assign clearing  = (st_r == S_CLR);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // sequencer next state and memory controls
  always_comb begin
    logic [63:0] base, d;
    logic        run, term, stay, ok;
    logic [23:0] nslice;
    rec_t        nrec;

    st_nxt = st_r;      ret_nxt = ret_r;     cmd_nxt = cmd_r;
    clr_nxt = clr_r;    running_nxt = running_r;
    s_nxt = s_r;        sh_nxt = sh_r;       head_nxt = head_r;
    tail_nxt = tail_r;  qreg_nxt = qreg_r;   cur_nxt = cur_r;
    prev_nxt = prev_r;  lv_nxt = lv_r;       last_nxt = last_r;
    ws_nxt = ws_r;      diff_nxt = diff_r;   force_nxt = force_r;
    spend_nxt = spend_r; forced_nxt = forced_r; tosleep_nxt = tosleep_r;
    rmsl_nxt = rmsl_r;  found_nxt = found_r; acc_nxt = acc_r;
    sw_nxt = sw_r;      out_nxt = out_r;
    ov_nxt = ov_r && !out_ready;
    q_pop   = 1'b0;
    rec_ra  = running_r; rec_we = 1'b0; rec_wa = running_r; rec_wd = rec_q;
    wake_ra = '0; wake_we = 1'b0; wake_wa = '0; wake_wd = '0;
    link_ra = '0; link_we = 1'b0; link_wa = '0; link_wd = NIL;
    base = '0; d = '0; run = 1'b0; term = 1'b0; stay = 1'b0; ok = 1'b0;
    nslice = rec_q.slice; nrec = rec_q;

    // quantum registers
    if (cfg_valid && 32'(cfg_index) < 32'(CFG_REGS) && 32'(cfg_index) < 32'(LEVELS)
        && cfg_data != '0) begin
      qreg_nxt[cfg_index[LVW-1:0]] = cfg_data;
    end

    unique case (st_r)
      // clearing pass over the slot memories after reset
      S_CLR: begin
        rec_we  = 1'b1;
        rec_wa  = clr_r;
        rec_wd  = '0;
        if (clr_r == '0) begin
          rec_wd.status  = ST_RUN;
          rec_wd.slice   = quantum_reset(0);
          rec_wd.quantum = quantum_reset(0);
        end
        wake_we = 1'b1;
        wake_wa = clr_r;
        wake_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SW'(TASK_SLOTS - 1)) st_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (q_data.op == OP_READY || q_data.op == OP_SETPRI) rec_ra = SW'(q_data.slot);
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          acc_nxt = (q_data.op == OP_TICK);
          sw_nxt  = 1'b0;
          unique case (q_data.op) inside
            OP_TICK:            st_nxt = S_T0;
            OP_READY:           st_nxt = S_R1;
            OP_YIELD, OP_SLEEP: st_nxt = S_Y1;
            OP_EXIT:            st_nxt = S_X1;
            OP_SETPRI:          st_nxt = S_S1;
            default:            st_nxt = S_FIN0;
          endcase
        end
      end

      // elapsed time since the last tick, saturated to slice width
      S_T0: begin
        base = (last_r == '0) ? cmd_r.now : last_r;
        d    = (cmd_r.now >= base) ? cmd_r.now - base : '0;
        diff_nxt = (d[63:24] != '0) ? '1 : d[23:0];
        last_nxt = cmd_r.now;
        st_nxt   = S_W0;
      end

      // wake expired sleepers from the head of the sleep list
      S_W0: begin
        rec_ra  = sh_r[SW-1:0];
        wake_ra = sh_r[SW-1:0];
        link_ra = sh_r[SW-1:0];
        st_nxt  = (sh_r == NIL) ? S_WDONE : S_W1;
      end

      S_W1: begin
        if (wake_q <= cmd_r.now) begin
          s_nxt  = sh_r[SW-1:0];
          sh_nxt = link_q;
          rec_we = 1'b1;
          rec_wa = sh_r[SW-1:0];
          rec_wd = '{status: ST_READY, level: rec_q.level,
                     slice: rec_q.quantum, quantum: rec_q.quantum};
          lv_nxt  = rec_q.level;
          ret_nxt = S_W0;
          st_nxt  = S_P0;
        end else begin
          st_nxt = S_WDONE;
        end
      end

      S_WDONE: begin
        forced_nxt  = force_r;
        tosleep_nxt = spend_r;
        force_nxt   = 1'b0;
        spend_nxt   = 1'b0;
        st_nxt      = S_T2;
      end

      // charge the running task and decide on preemption
      S_T2: begin
        run  = (rec_q.status == ST_RUN);
        term = (rec_q.status == ST_TERM);
        if (run) nslice = (diff_r < rec_q.slice) ? rec_q.slice - diff_r : '0;
        stay = !(forced_r || term) && run && (nslice != '0) && (hr_lv <= rec_q.level);
        nrec.slice = nslice;
        st_nxt = S_FIN0;
        if (!stay) begin
          sw_nxt = 1'b1;
          st_nxt = S_SEL;
          if (tosleep_r && run && running_r != '0) begin
            nrec.status = ST_SLEEP;
            s_nxt   = running_r;
            ret_nxt = S_SEL;
            st_nxt  = S_SI0;
          end else if (term) begin
            nrec.status = ST_FREE;
          end else if (run) begin
            nrec.status = ST_READY;
            nrec.slice  = rec_q.quantum;
            if (running_r != '0) begin
              s_nxt   = running_r;
              lv_nxt  = rec_q.level;
              ret_nxt = S_SEL;
              st_nxt  = S_P0;
            end
          end
        end
        rec_we = 1'b1;
        rec_wa = running_r;
        rec_wd = nrec;
      end

      // pick the head of the highest ready level, else the idle task
      S_SEL: begin
        if (hr_found) begin
          rec_ra    = head_r[hr_lv[LVW-1:0]][SW-1:0];
          link_ra   = head_r[hr_lv[LVW-1:0]][SW-1:0];
          cur_nxt   = head_r[hr_lv[LVW-1:0]];
          lv_nxt    = hr_lv;
          found_nxt = 1'b1;
        end else begin
          rec_ra    = '0;
          cur_nxt   = '0;
          found_nxt = 1'b0;
        end
        st_nxt = S_DISP;
      end

      S_DISP: begin
        if (found_r) begin
          head_nxt[lv_r[LVW-1:0]] = link_q;
          if (link_q == NIL) tail_nxt[lv_r[LVW-1:0]] = NIL;
        end
        rec_we = 1'b1;
        rec_wa = cur_r[SW-1:0];
        rec_wd = '{status: ST_RUN, level: rec_q.level,
                   slice: rec_q.quantum, quantum: rec_q.quantum};
        running_nxt = cur_r[SW-1:0];
        st_nxt = S_FIN0;
      end

      // make ready
      S_R1: begin
        ok = cmd_r.req_ok && (cmd_r.slot != '0) &&
             (rec_q.status == ST_FREE || rec_q.status == ST_SLEEP);
        st_nxt = S_FIN0;
        if (ok) begin
          nrec.status = ST_READY;
          if (rec_q.status == ST_FREE) begin
            nrec.level   = cmd_r.level;
            nrec.quantum = qreg_r[cmd_r.level[LVW-1:0]];
          end
          nrec.slice = nrec.quantum;
          rec_we  = 1'b1;
          rec_wa  = SW'(cmd_r.slot);
          rec_wd  = nrec;
          wake_we = 1'b1;
          wake_wa = SW'(cmd_r.slot);
          wake_wd = '0;
          force_nxt = 1'b1;
          acc_nxt   = 1'b1;
          s_nxt     = SW'(cmd_r.slot);
          lv_nxt    = nrec.level;
          if (rec_q.status == ST_SLEEP) begin
            rmsl_nxt = 1'b1;
            ret_nxt  = S_R2;
            st_nxt   = S_RM0;
          end else begin
            ret_nxt = S_FIN0;
            st_nxt  = S_P0;
          end
        end
      end

      S_R2: begin
        ret_nxt = S_FIN0;
        st_nxt  = S_P0;
      end

      // yield and sleep
      S_Y1: begin
        st_nxt = S_FIN0;
        if (rec_q.status == ST_RUN) begin
          nrec.slice = '0;
          if (cmd_r.plain) begin
            rec_we    = 1'b1;
            rec_wd    = nrec;
            force_nxt = 1'b1;
            acc_nxt   = 1'b1;
          end else if (running_r != '0) begin
            rec_we    = 1'b1;
            rec_wd    = nrec;
            wake_we   = 1'b1;
            wake_wa   = running_r;
            wake_wd   = cmd_r.wake;
            spend_nxt = 1'b1;
            force_nxt = 1'b1;
            acc_nxt   = 1'b1;
          end
        end
      end

      // exit of the running task
      S_X1: begin
        st_nxt = S_FIN0;
        if (rec_q.status == ST_RUN && running_r != '0) begin
          nrec.status = ST_TERM;
          rec_we    = 1'b1;
          rec_wd    = nrec;
          force_nxt = 1'b1;
          spend_nxt = 1'b0;
          acc_nxt   = 1'b1;
        end
      end

      // set priority, requeue a ready task at its new level
      S_S1: begin
        ok = cmd_r.req_ok && rec_q.status != ST_FREE && rec_q.status != ST_TERM;
        st_nxt = S_FIN0;
        if (ok) begin
          nrec.level   = cmd_r.level;
          nrec.quantum = qreg_r[cmd_r.level[LVW-1:0]];
          nrec.slice   = nrec.quantum;
          rec_we  = 1'b1;
          rec_wa  = SW'(cmd_r.slot);
          rec_wd  = nrec;
          acc_nxt = 1'b1;
          if (rec_q.status == ST_READY && cmd_r.slot != '0) begin
            s_nxt    = SW'(cmd_r.slot);
            lv_nxt   = rec_q.level;
            rmsl_nxt = 1'b0;
            ret_nxt  = S_S2;
            st_nxt   = S_RM0;
          end
        end
      end

      S_S2: begin
        lv_nxt  = cmd_r.level;
        ret_nxt = S_FIN0;
        st_nxt  = S_P0;
      end

      // push slot s at the tail of level lv
      S_P0: begin
        link_we = 1'b1;
        link_wa = s_r;
        link_wd = NIL;
        if (tail_r[lv_r[LVW-1:0]] != NIL) begin
          st_nxt = S_P1;
        end else begin
          head_nxt[lv_r[LVW-1:0]] = PW'(s_r);
          tail_nxt[lv_r[LVW-1:0]] = PW'(s_r);
          st_nxt = ret_r;
        end
      end

      S_P1: begin
        link_we = 1'b1;
        link_wa = tail_r[lv_r[LVW-1:0]][SW-1:0];
        link_wd = PW'(s_r);
        tail_nxt[lv_r[LVW-1:0]] = PW'(s_r);
        st_nxt = ret_r;
      end

      // unlink slot s from the sleep list or from level lv
      S_RM0: begin
        prev_nxt = NIL;
        cur_nxt  = rmsl_r ? sh_r : head_r[lv_r[LVW-1:0]];
        st_nxt   = S_RM1;
      end

      S_RM1: begin
        link_ra = cur_r[SW-1:0];
        st_nxt  = (cur_r == NIL) ? ret_r : S_RM2;
      end

      S_RM2: begin
        if (cur_r == PW'(s_r)) begin
          if (prev_r == NIL) begin
            if (rmsl_r) sh_nxt = link_q;
            else head_nxt[lv_r[LVW-1:0]] = link_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_r[SW-1:0];
            link_wd = link_q;
          end
          if (!rmsl_r && tail_r[lv_r[LVW-1:0]] == PW'(s_r)) begin
            tail_nxt[lv_r[LVW-1:0]] = prev_r;
          end
          st_nxt = ret_r;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          st_nxt   = S_RM1;
        end
      end

      // sorted insert of slot s into the sleep list, ties in arrival order
      S_SI0: begin
        wake_ra = s_r;
        st_nxt  = S_SI1;
      end

      S_SI1: begin
        ws_nxt  = wake_q;
        wake_ra = sh_r[SW-1:0];
        link_ra = sh_r[SW-1:0];
        if (sh_r == NIL) begin
          link_we = 1'b1;
          link_wa = s_r;
          link_wd = NIL;
          sh_nxt  = PW'(s_r);
          st_nxt  = ret_r;
        end else begin
          st_nxt = S_SI2;
        end
      end

      S_SI2: begin
        if (ws_r < wake_q) begin
          link_we = 1'b1;
          link_wa = s_r;
          link_wd = sh_r;
          sh_nxt  = PW'(s_r);
          st_nxt  = ret_r;
        end else begin
          prev_nxt = sh_r;
          cur_nxt  = link_q;
          st_nxt   = S_SI3;
        end
      end

      S_SI3: begin
        wake_ra = cur_r[SW-1:0];
        link_ra = cur_r[SW-1:0];
        st_nxt  = (cur_r == NIL) ? S_SI5 : S_SI4;
      end

      S_SI4: begin
        if (wake_q <= ws_r) begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          st_nxt   = S_SI3;
        end else begin
          st_nxt = S_SI5;
        end
      end

      S_SI5: begin
        link_we = 1'b1;
        link_wa = s_r;
        link_wd = cur_r;
        st_nxt  = S_SI6;
      end

      S_SI6: begin
        link_we = 1'b1;
        link_wa = prev_r[SW-1:0];
        link_wd = PW'(s_r);
        st_nxt  = ret_r;
      end

      // fetch the running task and post the result
      S_FIN0: begin
        st_nxt = S_FIN1;
      end

      S_FIN1: begin
        if (!ov_r || out_ready) begin
          out_nxt.running_task     = 6'(running_r);
          out_nxt.switched         = sw_r;
          out_nxt.running_priority = rec_q.level;
          out_nxt.slice_left       = rec_q.slice;
          out_nxt.accepted         = acc_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLR;
      ret_r     <= S_IDLE;
      clr_r     <= '0;
      running_r <= '0;
      sh_r      <= NIL;
      force_r   <= 1'b0;
      spend_r   <= 1'b0;
      last_r    <= '0;
      ov_r      <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= NIL;
        tail_r[l] <= NIL;
        qreg_r[l] <= quantum_reset(l);
      end
    end else begin
      st_r      <= st_nxt;
      ret_r     <= ret_nxt;
      clr_r     <= clr_nxt;
      running_r <= running_nxt;
      sh_r      <= sh_nxt;
      force_r   <= force_nxt;
      spend_r   <= spend_nxt;
      last_r    <= last_nxt;
      ov_r      <= ov_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      qreg_r    <= qreg_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    s_r       <= s_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    lv_r      <= lv_nxt;
    ws_r      <= ws_nxt;
    diff_r    <= diff_nxt;
    forced_r  <= forced_nxt;
    tosleep_r <= tosleep_nxt;
    rmsl_r    <= rmsl_nxt;
    found_r   <= found_nxt;
    acc_r     <= acc_nxt;
    sw_r      <= sw_nxt;
    out_r     <= out_nxt;
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (wake_we) wake_mem[wake_wa] <= wake_wd;
    wake_q <= wake_mem[wake_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q <= link_mem[link_ra];
  end

  // a pending sleep always comes with a pending switch
  a_sleep_forces: assert property (@(posedge clk) disable iff (!rst_n)
    spend_r |-> force_r)
    else $error("sleep pending without switch pending");

  // a level queue is empty at head and tail together
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_CLR) |-> ht_ok)
    else $error("level head and tail disagree on empty");

  // a request taken from the queue starts work at once
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && q_valid) |=> (st_r != S_IDLE))
    else $error("request popped but sequencer stayed idle");

  // no request leaves the queue during the clearing pass
  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> !q_pop)
    else $error("request popped during clearing pass");

endmodule

// ===== bench/priority_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb: self-checking bench for the task scheduler
// Builds directed and random request streams, drives them through the input
// channel in bursts, predicts every result with an in-bench scheduler model
// and compares the result channel field by field. Quanta are reprogrammed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int NSLOT = TASK_SLOTS;
  localparam int NLV   = LEVELS;
  localparam logic [6:0] EMPTY = 7'(TASK_SLOTS);
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #1 clk = ~clk;

  priority_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ------------------------------------------------------------------------
  // scheduler model state
  // ------------------------------------------------------------------------
  logic [23:0] m_quant [8];
  logic [2:0]  m_level [NSLOT];
  logic [2:0]  m_status [NSLOT];
  logic [23:0] m_slice [NSLOT];
  logic [23:0] m_tq [NSLOT];
  logic [63:0] m_wake [NSLOT];
  logic [6:0]  m_next [NSLOT];
  logic [6:0]  m_head [NLV];
  logic [6:0]  m_tail [NLV];
  logic [6:0]  m_sleep_head;
  logic        m_force, m_sleepreq;
  logic [63:0] m_last_tick;
  logic [5:0]  m_run;

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   errors = 0;
  logic [63:0] clock_us = 64'd100;

  function automatic logic [2:0] norm_level(logic [2:0] p);
    return (p < NLV) ? p : NORMAL_LEVEL;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < 8; i++) m_quant[i] = (i < 5) ? quantum_reset(i) : 24'd12000;
    for (int i = 0; i < NSLOT; i++) begin
      m_level[i] = 0; m_status[i] = ST_FREE; m_slice[i] = 0; m_tq[i] = 0;
      m_wake[i] = 0; m_next[i] = 0;
    end
    for (int i = 0; i < NLV; i++) begin
      m_head[i] = EMPTY; m_tail[i] = EMPTY;
    end
    m_sleep_head = EMPTY; m_force = 0; m_sleepreq = 0; m_last_tick = 0; m_run = 0;
    m_status[0] = ST_RUN; m_tq[0] = m_quant[0]; m_slice[0] = m_quant[0];
  endtask

  task automatic enqueue(logic [6:0] s);
    logic [2:0] lv;
    lv = m_level[s];
    m_next[s] = EMPTY;
    if (m_tail[lv] != EMPTY) m_next[m_tail[lv]] = s;
    else m_head[lv] = s;
    m_tail[lv] = s;
  endtask

  task automatic dequeue(int lv, output logic [6:0] h);
    h = m_head[lv];
    if (h != EMPTY) begin
      m_head[lv] = m_next[h];
      if (m_head[lv] == EMPTY) m_tail[lv] = EMPTY;
      m_next[h] = EMPTY;
    end
  endtask

  task automatic unlink_ready(logic [6:0] s, int lv);
    logic [6:0] prev, cur;
    prev = EMPTY; cur = m_head[lv];
    while (cur != EMPTY && cur != s) begin prev = cur; cur = m_next[cur]; end
    if (cur == s) begin
      if (prev == EMPTY) m_head[lv] = m_next[s];
      else m_next[prev] = m_next[s];
      if (m_tail[lv] == s) m_tail[lv] = prev;
      m_next[s] = EMPTY;
    end
  endtask

  task automatic sleep_link(logic [6:0] s);
    logic [6:0] node;
    node = m_sleep_head;
    if (node == EMPTY || m_wake[s] < m_wake[node]) begin
      m_next[s] = node; m_sleep_head = s;
    end else begin
      while (m_next[node] != EMPTY && m_wake[m_next[node]] <= m_wake[s]) node = m_next[node];
      m_next[s] = m_next[node];
      m_next[node] = s;
    end
  endtask

  task automatic sleep_unlink(logic [6:0] s);
    logic [6:0] prev, cur;
    prev = EMPTY; cur = m_sleep_head;
    while (cur != EMPTY && cur != s) begin prev = cur; cur = m_next[cur]; end
    if (cur == s) begin
      if (prev == EMPTY) m_sleep_head = m_next[s];
      else m_next[prev] = m_next[s];
      m_next[s] = EMPTY;
    end
  endtask

  function automatic int top_ready_level();
    for (int lv = NLV - 1; lv >= 0; lv--) if (m_head[lv] != EMPTY) return lv;
    return 0;
  endfunction

  // tick: wake sleepers, charge time, maybe dispatch; returns switched
  task automatic tick_step(logic [63:0] now, output logic sw);
    logic [63:0] diff;
    logic forced, go_sleep;
    logic [6:0] r, nxt, s;
    r = {1'b0, m_run}; nxt = EMPTY; sw = 0;
    if (m_last_tick == 0) m_last_tick = now;
    diff = (now >= m_last_tick) ? now - m_last_tick : 64'd0;
    m_last_tick = now;
    while (m_sleep_head != EMPTY && m_wake[m_sleep_head] <= now) begin
      s = m_sleep_head;
      m_sleep_head = m_next[s];
      m_status[s] = ST_READY;
      m_slice[s] = m_tq[s];
      enqueue(s);
    end
    forced = m_force; go_sleep = m_sleepreq;
    m_force = 0; m_sleepreq = 0;
    if (m_status[r] == ST_RUN)
      m_slice[r] = (diff < 64'(m_slice[r])) ? m_slice[r] - 24'(diff) : 24'd0;
    if (m_status[r] == ST_TERM) forced = 1;
    if (!forced && m_status[r] == ST_RUN && m_slice[r] > 0 && top_ready_level() <= m_level[r])
      return;
    if (go_sleep && m_status[r] == ST_RUN && r != 0) begin
      m_status[r] = ST_SLEEP;
      sleep_link(r);
    end else if (m_status[r] == ST_TERM) begin
      m_status[r] = ST_FREE;
    end else if (m_status[r] == ST_RUN) begin
      m_slice[r] = m_tq[r];
      m_status[r] = ST_READY;
      if (r != 0) enqueue(r);
    end
    for (int lv = NLV - 1; lv >= 0 && nxt == EMPTY; lv--) dequeue(lv, nxt);
    if (nxt == EMPTY) nxt = 0;
    m_status[nxt] = ST_RUN;
    m_slice[nxt] = m_tq[nxt];
    m_run = nxt[5:0];
    sw = 1;
  endtask

  task automatic predict_request(in_t rq, output out_t res);
    logic sw, ok, queued;
    logic [6:0] q;
    logic [2:0] lv;
    logic [63:0] w;
    logic [6:0] r;
    sw = 0; ok = 0; q = {1'b0, rq.task_req}; r = {1'b0, m_run};
    case (rq.mode)
      MODE_TICK: begin
        tick_step(rq.now_us, sw);
        ok = 1;
      end
      MODE_READY: begin
        if (q != 0 && (m_status[q] == ST_FREE || m_status[q] == ST_SLEEP)) begin
          if (m_status[q] == ST_FREE) begin
            m_level[q] = norm_level(rq.priority_req);
            m_tq[q] = m_quant[m_level[q]];
          end else sleep_unlink(q);
          m_wake[q] = 0;
          m_status[q] = ST_READY;
          m_slice[q] = m_tq[q];
          enqueue(q);
          m_force = 1; ok = 1;
        end
      end
      MODE_YIELD, MODE_SLEEP: begin
        if (m_status[r] == ST_RUN) begin
          if (rq.mode == MODE_YIELD || rq.sleep_us == 0) begin
            m_slice[r] = 0; m_force = 1; ok = 1;
          end else if (r != 0) begin
            w = rq.now_us + 64'(rq.sleep_us);
            m_wake[r] = (w < rq.now_us) ? '1 : w;
            m_slice[r] = 0; m_sleepreq = 1; m_force = 1; ok = 1;
          end
        end
      end
      MODE_EXIT: begin
        if (m_status[r] == ST_RUN && r != 0) begin
          m_status[r] = ST_TERM; m_force = 1; m_sleepreq = 0; ok = 1;
        end
      end
      MODE_SETPRI: begin
        if (m_status[q] != ST_FREE && m_status[q] != ST_TERM) begin
          lv = norm_level(rq.priority_req);
          queued = (m_status[q] == ST_READY) && q != 0;
          if (queued) unlink_ready(q, m_level[q]);
          m_level[q] = lv;
          m_tq[q] = m_quant[lv];
          m_slice[q] = m_tq[q];
          if (queued) enqueue(q);
          ok = 1;
        end
      end
      default: ;
    endcase
    res.running_task = m_run;
    res.switched = sw;
    res.running_priority = m_level[m_run];
    res.slice_left = m_slice[m_run];
    res.accepted = ok;
  endtask

  // ------------------------------------------------------------------------
  // request driver: bursts with random gaps, hold-off on demand
  // ------------------------------------------------------------------------
  int  burst_left = 0, gap_left = 0;
  logic sender_hold = 0;

  always @(posedge clk) begin
    out_t pred;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_request(in_data, pred);
        expected_results.push_back(pred);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || sender_hold || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor with its own stall pattern
  // ------------------------------------------------------------------------
  int stall_mode = 0;
  int long_hold = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: result mismatch expected task=%0d sw=%0d pri=%0d slice=%0d acc=%0d",
                     $realtime, want.running_task, want.switched, want.running_priority,
                     want.slice_left, want.accepted);
            $display("%0t:                 actual task=%0d sw=%0d pri=%0d slice=%0d acc=%0d",
                     $realtime, out_data.running_task, out_data.switched,
                     out_data.running_priority, out_data.slice_left, out_data.accepted);
            errors <= errors + 1;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready <= 1'b0;
      end else case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      // watchdog on lack of progress
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic in_t mk(logic [2:0] md, logic [5:0] t, logic [2:0] p,
                             logic [63:0] now, logic [31:0] d);
    in_t x;
    x.mode = md; x.task_req = t; x.priority_req = p; x.now_us = now; x.sleep_us = d;
    return x;
  endfunction

  function automatic logic [31:0] rand_dur();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  task automatic add_random(int n);
    in_t x;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) clock_us = {$urandom, $urandom};  // time jump, may run backwards
      else clock_us = clock_us + $urandom_range(0, 5000);
      x = mk(MODE_TICK, 6'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), clock_us,
             rand_dur());
      if ($urandom_range(0, 9) == 0) x.task_req = 6'($urandom_range(0, 63));
      if (k < 40) x.mode = MODE_TICK;
      else if (k < 60) x.mode = MODE_READY;
      else if (k < 68) x.mode = MODE_YIELD;
      else if (k < 80) x.mode = MODE_SLEEP;
      else if (k < 87) x.mode = MODE_EXIT;
      else if (k < 97) x.mode = MODE_SETPRI;
      else x.mode = 3'($urandom_range(6, 7));
      pending_reqs.push_back(x);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic ref_quantum_write(logic [2:0] idx, logic [23:0] val);
    if (idx < CFG_REGS && val != 0) m_quant[idx] = val;
  endtask

  // one register write; valid stays up for a following write
  task automatic write_quantum(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ref_quantum_write(idx, val);
  endtask

  task automatic program_all(int style);
    logic [23:0] v;
    for (int i = 0; i < CFG_REGS; i++) begin
      case (style)
        0: v = 24'd1;
        1: v = 24'hFFFFFF;
        2: v = (i == 0) ? 24'd0 : 24'($urandom_range(1, 3000));
        default: v = 24'($urandom_range(1, 30000));
      endcase
      write_quantum(3'(i), v);
    end
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_all(3);

    // directed: extremes, every operation, special cases
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd0, 0));
    pending_reqs.push_back(mk(MODE_READY, 0, 4, 64'd10, 0));        // slot 0 ignored
    pending_reqs.push_back(mk(MODE_READY, 63, 7, 64'd20, 0));       // level above max
    pending_reqs.push_back(mk(MODE_READY, 5, 4, 64'd30, 0));
    pending_reqs.push_back(mk(MODE_READY, 5, 1, 64'd31, 0));        // already ready
    pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 64'd35, 32'd50));  // idle cannot sleep
    pending_reqs.push_back(mk(MODE_EXIT, 0, 0, 64'd36, 0));         // idle cannot exit
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd40, 0));
    pending_reqs.push_back(mk(MODE_SETPRI, 5, 0, 64'd41, 0));
    pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, '1, 32'hFFFFFFFF)); // saturating wake
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd60, 0));
    pending_reqs.push_back(mk(MODE_READY, 5, 2, 64'd61, 0));        // pull out of sleep
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd20, 0));         // time backwards
    pending_reqs.push_back(mk(MODE_YIELD, 0, 0, 64'd70, 0));
    pending_reqs.push_back(mk(MODE_SLEEP, 0, 0, 64'd71, 0));        // zero means yield
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd80, 0));
    pending_reqs.push_back(mk(MODE_EXIT, 0, 0, 64'd81, 0));
    pending_reqs.push_back(mk(MODE_TICK, 0, 0, 64'd90, 0));         // frees exited slot
    pending_reqs.push_back(mk(MODE_SETPRI, 40, 3, 64'd91, 0));      // free slot ignored
    pending_reqs.push_back(mk(3'd6, 42, 5, 64'd92, 0));
    pending_reqs.push_back(mk(3'd7, 21, 2, 64'hAAAA_5555_AAAA_5555, 32'h5555AAAA));
    pending_reqs.push_back(mk(MODE_TICK, 0, 6, 64'hFFFF_FFFF_FFFF_FFF0, 0));
    wait_drained();

    program_all(0);
    add_random(450);
    wait_drained();

    // long receiver hold-off while the sender keeps pushing
    long_hold = 3000;
    add_random(450);
    wait_drained();

    program_all(1);
    clock_us = 64'd1000;
    add_random(450);
    // sender pause until everything returned, then resume
    sender_hold = 1;
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    sender_hold = 0;
    wait_drained();

    program_all(2);
    add_random(600);
    wait_drained();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
